// File: sv/obb_pkg.sv
package obb_pkg;

  localparam int COORD_BITS  = 16;
  localparam int TRIG_DEPTH  = 1024;

  localparam int HEAD_W      = 16;
  localparam int PHASE_W     = HEAD_W - 2;
  localparam int TRIG_W      = 16;
  localparam int TRIG_FRAC   = TRIG_W - 1;
  localparam int IDX_W       = $clog2(TRIG_DEPTH + 1);
  localparam int IDXP_W      = PHASE_W + IDX_W;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int EPROD_W     = COORD_BITS + TRIG_W;
  localparam int RPROD_W     = DIFF_W + TRIG_W;
  localparam int SUM_W       = COORD_BITS + TRIG_W + 3;
  localparam int NUM_STAGES  = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXT_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_TOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_BOTTOM = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam longint signed EXT_LEFT_RST   = -160;
  localparam longint signed EXT_RIGHT_RST  = 160;
  localparam longint signed EXT_TOP_RST    = -240;
  localparam longint signed EXT_BOTTOM_RST = 240;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint signed   ONE_Q30 = 64'sd1073741824;

  localparam int ANGLE_SHIFT  = $clog2(2 * TRIG_DEPTH);
  localparam int TAYLOR_SHIFT = 41;

  // exact floor division by (2n)(2n+1) for numerators below 2^32
  localparam longint unsigned TAYLOR_RECIP [1:10] = '{
    ((64'd1 << TAYLOR_SHIFT) + 64'd5)   / 64'd6,
    ((64'd1 << TAYLOR_SHIFT) + 64'd19)  / 64'd20,
    ((64'd1 << TAYLOR_SHIFT) + 64'd41)  / 64'd42,
    ((64'd1 << TAYLOR_SHIFT) + 64'd71)  / 64'd72,
    ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110,
    ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156,
    ((64'd1 << TAYLOR_SHIFT) + 64'd209) / 64'd210,
    ((64'd1 << TAYLOR_SHIFT) + 64'd271) / 64'd272,
    ((64'd1 << TAYLOR_SHIFT) + 64'd341) / 64'd342,
    ((64'd1 << TAYLOR_SHIFT) + 64'd419) / 64'd420
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]     trig_t;
  typedef logic [NUM_STAGES:1]          stage_adv_t;

  typedef struct packed {
    coord_t bottom;
    coord_t top;
    coord_t right;
    coord_t left;
  } bounds_t;

  typedef struct packed {
    coord_t           rect_bottom;
    coord_t           rect_top;
    coord_t           rect_right;
    coord_t           rect_left;
    logic [HEAD_W-1:0] heading;
    coord_t           center_y;
    coord_t           center_x;
  } item_t;

  typedef struct packed {
    logic [3:0][SUM_W-1:0] box_x;
    logic [3:0][SUM_W-1:0] box_y;
    logic [3:0][SUM_W-1:0] bar_x;
    logic [3:0][SUM_W-1:0] bar_y;
  } sums_t;

  typedef logic [TRIG_W-2:0] sin_rom_t [0:TRIG_DEPTH];

  function automatic logic [TRIG_W-2:0] sin_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    logic [127:0]    wide;
    longint signed   sum;
    longint signed   r;
    int unsigned     n;
    x    = (PI_Q30 * 64'(k)) >> ANGLE_SHIFT;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 10; n++) begin
      term = (term * x2) >> 30;
      wide = 128'(term) * 128'(TAYLOR_RECIP[n]);
      term = 64'(wide >> TAYLOR_SHIFT);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return r[TRIG_W-2:0];
  endfunction

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t t;
    for (int k = 0; k <= TRIG_DEPTH; k++) t[k] = sin_entry(k);
    return t;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// File: sv/obb_trig.sv
module obb_trig
  import obb_pkg::*;
(
  input  logic              clk,
  input  stage_adv_t        adv,
  input  logic [HEAD_W-1:0] heading,
  output trig_t             sin_val,
  output trig_t             cos_val
);

  logic [1:0]        quad1;
  logic [IDX_W-1:0]  idx1;
  logic [1:0]        quad2;
  logic [TRIG_W-2:0] t_lo;
  logic [TRIG_W-2:0] t_hi;
  logic [IDXP_W-1:0] idx_prod;
  trig_t             pos_lo;
  trig_t             pos_hi;

  assign idx_prod = IDXP_W'(heading[PHASE_W-1:0]) * IDXP_W'(TRIG_DEPTH);
  assign pos_lo   = $signed({1'b0, t_lo});
  assign pos_hi   = $signed({1'b0, t_hi});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      quad1 <= heading[HEAD_W-1 -: 2];
      idx1  <= IDX_W'(idx_prod >> PHASE_W);
    end
    if (adv[2]) begin
      quad2 <= quad1;
      t_lo  <= SIN_ROM[idx1];
      t_hi  <= SIN_ROM[IDX_W'(TRIG_DEPTH) - idx1];
    end
    if (adv[3]) begin
      case (quad2)
        QUAD_0: begin
          sin_val <= pos_lo;
          cos_val <= pos_hi;
        end
        QUAD_1: begin
          sin_val <= pos_hi;
          cos_val <= -pos_lo;
        end
        QUAD_2: begin
          sin_val <= -pos_lo;
          cos_val <= -pos_hi;
        end
        default: begin
          sin_val <= -pos_hi;
          cos_val <= pos_lo;
        end
      endcase
    end
  end

endmodule

// File: sv/obb_rot.sv
module obb_rot
  import obb_pkg::*;
(
  input  logic       clk,
  input  stage_adv_t adv,
  input  item_t      item,
  input  bounds_t    ext,
  input  trig_t      sin_val,
  input  trig_t      cos_val,
  output sums_t      sums,
  output bounds_t    rect
);

  item_t                      item1;
  coord_t                     cx2, cy2, cx3, cy3, cx4, cy4;
  bounds_t                    rect2, rect3, rect4;
  logic signed [DIFF_W-1:0]   dx2 [2];
  logic signed [DIFF_W-1:0]   dy2 [2];
  logic signed [DIFF_W-1:0]   dx3 [2];
  logic signed [DIFF_W-1:0]   dy3 [2];
  logic signed [EPROD_W-1:0]  exc [2];
  logic signed [EPROD_W-1:0]  exs [2];
  logic signed [EPROD_W-1:0]  eyc [2];
  logic signed [EPROD_W-1:0]  eys [2];
  logic signed [RPROD_W-1:0]  dxc [2];
  logic signed [RPROD_W-1:0]  dxs [2];
  logic signed [RPROD_W-1:0]  dyc [2];
  logic signed [RPROD_W-1:0]  dys [2];
  coord_t                     ex  [2];
  coord_t                     ey  [2];

  assign ex[0] = ext.left;
  assign ex[1] = ext.right;
  assign ey[0] = ext.top;
  assign ey[1] = ext.bottom;

  always_ff @(posedge clk) begin
    if (adv[1]) item1 <= item;
    if (adv[2]) begin
      cx2      <= item1.center_x;
      cy2      <= item1.center_y;
      rect2    <= '{bottom: item1.rect_bottom, top: item1.rect_top,
                    right: item1.rect_right, left: item1.rect_left};
      dx2[0]   <= DIFF_W'(item1.rect_left)   - DIFF_W'(item1.center_x);
      dx2[1]   <= DIFF_W'(item1.rect_right)  - DIFF_W'(item1.center_x);
      dy2[0]   <= DIFF_W'(item1.rect_top)    - DIFF_W'(item1.center_y);
      dy2[1]   <= DIFF_W'(item1.rect_bottom) - DIFF_W'(item1.center_y);
    end
    if (adv[3]) begin
      cx3   <= cx2;
      cy3   <= cy2;
      rect3 <= rect2;
      dx3   <= dx2;
      dy3   <= dy2;
    end
    if (adv[4]) begin
      cx4   <= cx3;
      cy4   <= cy3;
      rect4 <= rect3;
      for (int k = 0; k < 2; k++) begin
        exc[k] <= ex[k] * cos_val;
        exs[k] <= ex[k] * sin_val;
        eyc[k] <= ey[k] * cos_val;
        eys[k] <= ey[k] * sin_val;
        dxc[k] <= dx3[k] * cos_val;
        dxs[k] <= dx3[k] * sin_val;
        dyc[k] <= dy3[k] * cos_val;
        dys[k] <= dy3[k] * sin_val;
      end
    end
    if (adv[5]) begin
      rect <= rect4;
      for (int a = 0; a < 2; a++) begin
        for (int b = 0; b < 2; b++) begin
          sums.box_x[2*a+b] <= SUM_W'(exc[b]) - SUM_W'(eys[a])
                               + (SUM_W'(cx4) <<< TRIG_FRAC);
          sums.box_y[2*a+b] <= SUM_W'(exs[b]) + SUM_W'(eyc[a])
                               + (SUM_W'(cy4) <<< TRIG_FRAC);
          sums.bar_x[2*a+b] <= SUM_W'(dxc[b]) + SUM_W'(dys[a]);
          sums.bar_y[2*a+b] <= SUM_W'(dyc[a]) - SUM_W'(dxs[b]);
        end
      end
    end
  end

endmodule

// File: sv/obb_cmp.sv
module obb_cmp
  import obb_pkg::*;
(
  input  logic       clk,
  input  stage_adv_t adv,
  input  sums_t      sums,
  input  bounds_t    rect,
  input  bounds_t    ext,
  output logic       hit
);

  logic signed [SUM_W-1:0] rl, rr, rt, rb, el, er, et, eb;
  logic [3:0]              box_in;
  logic [3:0]              bar_in;

  assign rl = SUM_W'(rect.left)   <<< TRIG_FRAC;
  assign rr = SUM_W'(rect.right)  <<< TRIG_FRAC;
  assign rt = SUM_W'(rect.top)    <<< TRIG_FRAC;
  assign rb = SUM_W'(rect.bottom) <<< TRIG_FRAC;
  assign el = SUM_W'(ext.left)    <<< TRIG_FRAC;
  assign er = SUM_W'(ext.right)   <<< TRIG_FRAC;
  assign et = SUM_W'(ext.top)     <<< TRIG_FRAC;
  assign eb = SUM_W'(ext.bottom)  <<< TRIG_FRAC;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      box_in[k] = ($signed(sums.box_x[k]) >= rl) && ($signed(sums.box_x[k]) <= rr)
               && ($signed(sums.box_y[k]) >= rt) && ($signed(sums.box_y[k]) <= rb);
      bar_in[k] = ($signed(sums.bar_x[k]) >= el) && ($signed(sums.bar_x[k]) <= er)
               && ($signed(sums.bar_y[k]) >= et) && ($signed(sums.bar_y[k]) <= eb);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) hit <= (|box_in) | (|bar_in);
  end

endmodule

// File: sv/oriented_box_overlap_check.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata[111:0] query item
// m_*       out        m_tvalid/m_tready  m_tdata[7:0]   hit flag
// cfg_*     in         cfg_we             cfg_index, cfg_data extent registers
//
// Six register stages: index, sine table read, sign select, multiply, sum, compare.
// One item per cycle is taken at full throughput, while m_tready does not stall the output.
// The sine table read (two ports, registered) sets stage two.
// rst clears all valid bits and restores the extents; no clearing pass is needed.
// Each stage stalls only when it is full and the next one cannot take; bubbles fill.
module oriented_box_overlap_check
  import obb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // center_x, center_y, heading, rect_left, rect_right, rect_top, rect_bottom
  input  logic [111:0]          s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, then seven zero bits
  output logic [7:0]            m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  logic [NUM_STAGES:1] valid;
  stage_adv_t          adv;
  bounds_t             ext;
  item_t               item;
  trig_t               sin_val;
  trig_t               cos_val;
  sums_t               sums;
  bounds_t             rect;
  logic                hit;

  assign item = item_t'(s_tdata);

  always_comb begin
    adv[NUM_STAGES] = !valid[NUM_STAGES] || m_tready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) adv[k] = !valid[k] || adv[k+1];
  end

  assign s_tready = adv[1];
  assign m_tvalid = valid[NUM_STAGES];
  assign m_tdata  = {7'd0, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      ext.left   <= COORD_BITS'(EXT_LEFT_RST);
      ext.right  <= COORD_BITS'(EXT_RIGHT_RST);
      ext.top    <= COORD_BITS'(EXT_TOP_RST);
      ext.bottom <= COORD_BITS'(EXT_BOTTOM_RST);
    end else begin
      if (adv[1]) valid[1] <= s_tvalid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) valid[k] <= valid[k-1];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EXT_LEFT:   ext.left   <= cfg_data;
          REG_EXT_RIGHT:  ext.right  <= cfg_data;
          REG_EXT_TOP:    ext.top    <= cfg_data;
          REG_EXT_BOTTOM: ext.bottom <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  obb_trig u_trig (
    .clk     (clk),
    .adv     (adv),
    .heading (item.heading),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  obb_rot u_rot (
    .clk     (clk),
    .adv     (adv),
    .item    (item),
    .ext     (ext),
    .sin_val (sin_val),
    .cos_val (cos_val),
    .sums    (sums),
    .rect    (rect)
  );

  obb_cmp u_cmp (
    .clk  (clk),
    .adv  (adv),
    .sums (sums),
    .rect (rect),
    .ext  (ext),
    .hit  (hit)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  a_result_advances: assert property (@(posedge clk) disable iff (rst)
    (valid[NUM_STAGES-1] && adv[NUM_STAGES]) |=> m_tvalid)
    else $error("item lost before output stage");

  a_flush_on_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (valid[1] && !adv[2]) |=> valid[1])
    else $error("first stage dropped item under stall");

endmodule
